// ===== src/gwc_pkg.sv =====
// ============================================================================
// gwc_pkg
// Shared constants, types and the tap class table of the Gaussian window
// convolution.
// ============================================================================
package gwc_pkg;

  // kernel geometry, supported kernel sizes 3 to 5
  localparam int FILTER_SPAN = 5;
  localparam int HALF_K      = FILTER_SPAN >> 1;
  localparam int WIN         = 2 * HALF_K + 1;

  // image limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // field widths
  localparam int PIX_W      = 16;
  localparam int WGT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;

  // counters and dimensions
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int SROW_W = $clog2(MAX_HEIGHT + 2 * HALF_K);
  localparam int LAG_W  = $clog2(HALF_K * MAX_WIDTH + HALF_K + 1);
  localparam int RMSK_W = H_W + 1;
  localparam int CMSK_W = W_W + 1;

  // line memory: one entry per column, holding the previous WIN-1 rows
  localparam int LINE_W = (WIN - 1) * PIX_W;

  // datapath
  localparam int NUM_CLS   = 6;
  localparam int CLS_IDX_W = 3;
  localparam int CLS_W     = PIX_W + 3;
  localparam int PROD_W    = CLS_W + WGT_W + 1;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_W    = 16;
  localparam int Q_W       = ACC_W - FRAC_W;
  localparam int PIX_MAX   = 2 ** (PIX_W - 1) - 1;
  localparam int PIX_MIN   = -(2 ** (PIX_W - 1));

  // reset values
  localparam int RST_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_HEIGHT = (MAX_HEIGHT < 768) ? MAX_HEIGHT : 768;
  localparam int RST_LAG    = HALF_K * RST_WIDTH + HALF_K;
  localparam int RST_CENTER = 65535;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [WGT_W-1:0]        wgt_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CLS_IDX_W-1:0]    cls_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd1;
  localparam cfg_idx_t CFG_WEIGHT_BASE  = 3'd2;

  // weight classes by squared distance from the center
  localparam cls_idx_t CLS_CENTER   = 3'd0;
  localparam cls_idx_t CLS_EDGE_ONE = 3'd1;
  localparam cls_idx_t CLS_DIAG_ONE = 3'd2;
  localparam cls_idx_t CLS_EDGE_TWO = 3'd3;
  localparam cls_idx_t CLS_KNIGHT   = 3'd4;
  localparam cls_idx_t CLS_DIAG_TWO = 3'd5;

  function automatic cls_idx_t tap_class(input int col, input int row);
    int dx;
    int dy;
    int dsq;
    cls_idx_t cls;
    dx  = (col > HALF_K) ? col - HALF_K : HALF_K - col;
    dy  = (row > HALF_K) ? row - HALF_K : HALF_K - row;
    dsq = dx * dx + dy * dy;
    unique case (dsq)
      0:       cls = CLS_CENTER;
      1:       cls = CLS_EDGE_ONE;
      2:       cls = CLS_DIAG_ONE;
      4:       cls = CLS_EDGE_TWO;
      5:       cls = CLS_KNIGHT;
      default: cls = CLS_DIAG_TWO;
    endcase
    return cls;
  endfunction

endpackage

// ===== src/gwc_ram.sv =====
// ============================================================================
// gwc_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ============================================================================
module gwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/gaussian_window_convolution.sv =====
// ============================================================================
// gaussian_window_convolution
// Streamed 2-D Gaussian window filter with zero padding, line memory of
// column entries, symmetric weights by distance class, round and saturate.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | sink      | in_valid / in_stall | in_action, in_pixel
//  out     | source    | out_valid/out_stall | out_filtered, out_frame_end
//  cfg     | sink      | cfg_wr_en           | cfg_index, cfg_wdata
//
//  one item per clock unless stalled; a result passes s1 to s6 and the output register
//  the line memory read and write-back of one column entry per item sets the rate
//  the whole pipeline holds while a result sits in the output register stalled
//  synchronous active-low reset; the line memory needs no clearing pass, every
//  in-range tap is written earlier in the same frame
//
module gaussian_window_convolution
  import gwc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [PIX_W-1:0] out_filtered,
  output logic                  out_frame_end,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [W_W-1:0]   w_r;
  logic [H_W-1:0]   h_r;
  logic [LAG_W-1:0] lag_r;
  wgt_t             wgt_r [NUM_CLS];

  logic [CFG_W_BITS-1:0] cfg_w_raw;
  logic [CFG_H_BITS-1:0] cfg_h_raw;
  logic [W_W-1:0]        cfg_w_eff;
  logic [H_W-1:0]        cfg_h_eff;
  logic [LAG_W-1:0]      cfg_lag;
  cfg_idx_t              cfg_wgt_idx;
  logic                  cfg_restart;

  // stream and output position
  logic [COL_W-1:0]  icol_r, icol_nxt;
  logic [SROW_W-1:0] irow_r, irow_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;
  logic [LAG_W-1:0]  lead_r, lead_nxt;

  logic adv;
  logic rows_done;
  logic take;
  logic gen;
  logic last_out;

  // stage 1: line memory data
  logic             s1_vld_r;
  logic             s1_gen_r;
  logic             s1_last_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;

  logic [LINE_W-1:0] line_rd_data;
  logic [LINE_W-1:0] line_old;
  logic [LINE_W-1:0] line_wr_data;
  logic              line_wr_en;
  logic              fwd_r, fwd_nxt;
  logic [LINE_W-1:0] fwd_data_r;
  pix_t              col_vec [WIN];
  logic [WIN-1:0]    rmask_nxt;
  logic [WIN-1:0]    cmask_nxt;
  logic [RMSK_W-1:0] row_tap;
  logic [CMSK_W-1:0] col_tap;

  // stage 2: window
  pix_t           win_r [WIN][WIN];
  logic           s2_vld_r;
  logic           s2_last_r;
  logic [WIN-1:0] s2_rmask_r;
  logic [WIN-1:0] s2_cmask_r;
  pix_t           mpix [WIN][WIN];

  // stage 3..6: arithmetic
  logic                    s3_vld_r, s3_last_r;
  logic signed [CLS_W-1:0] s3_cls_r [NUM_CLS];
  logic signed [CLS_W-1:0] s3_cls_nxt [NUM_CLS];

  logic                     s4_vld_r, s4_last_r;
  logic signed [PROD_W-1:0] s4_prod_r [NUM_CLS];
  logic signed [PROD_W-1:0] s4_prod_nxt [NUM_CLS];

  logic                     s5_vld_r, s5_last_r;
  logic signed [PAIR_W-1:0] s5_pair_r [NUM_CLS/2];
  logic signed [PAIR_W-1:0] s5_pair_nxt [NUM_CLS/2];

  logic                    s6_vld_r, s6_last_r;
  logic signed [ACC_W-1:0] s6_acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic signed [ACC_W-1:0] rnd;
  logic signed [Q_W-1:0]   qv;
  pix_t                    filt_nxt;

  // output register
  logic out_valid_r;
  pix_t out_filtered_r;
  logic out_frame_end_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_w_raw = cfg_wdata[CFG_W_BITS-1:0];
    cfg_h_raw = cfg_wdata[CFG_H_BITS-1:0];
    if (cfg_w_raw == '0) begin
      cfg_w_eff = W_W'(1);
    end else if (int'(cfg_w_raw) > MAX_WIDTH) begin
      cfg_w_eff = W_W'(MAX_WIDTH);
    end else begin
      cfg_w_eff = W_W'(cfg_w_raw);
    end
    if (cfg_h_raw == '0) begin
      cfg_h_eff = H_W'(1);
    end else if (int'(cfg_h_raw) > MAX_HEIGHT) begin
      cfg_h_eff = H_W'(MAX_HEIGHT);
    end else begin
      cfg_h_eff = H_W'(cfg_h_raw);
    end
    cfg_lag     = LAG_W'(HALF_K * int'(cfg_w_eff) + HALF_K);
    cfg_wgt_idx = cfg_index - CFG_WEIGHT_BASE;
    cfg_restart = cfg_wr_en &&
                  (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= W_W'(RST_WIDTH);
      h_r   <= H_W'(RST_HEIGHT);
      lag_r <= LAG_W'(RST_LAG);
      for (int n = 0; n < NUM_CLS; n++) begin
        wgt_r[n] <= (n == int'(CLS_CENTER)) ? WGT_W'(RST_CENTER) : '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          w_r   <= cfg_w_eff;
          lag_r <= cfg_lag;
        end
        CFG_IMAGE_HEIGHT: begin
          h_r <= cfg_h_eff;
        end
        default: begin
          wgt_r[cfg_wgt_idx] <= cfg_wdata[WGT_W-1:0];
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input side: positions and lag
  // --------------------------------------------------------------------------
  always_comb begin
    rows_done = irow_r >= SROW_W'(h_r);
    take      = in_valid && adv && (rows_done || !in_action);
    gen       = take && (lead_r == lag_r);
    last_out  = gen && (H_W'(orow_r) == h_r - H_W'(1)) &&
                (W_W'(ocol_r) == w_r - W_W'(1));

    icol_nxt = icol_r;
    irow_nxt = irow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    lead_nxt = lead_r;
    if (take) begin
      if (last_out) begin
        icol_nxt = '0;
        irow_nxt = '0;
        ocol_nxt = '0;
        orow_nxt = '0;
        lead_nxt = '0;
      end else begin
        if (W_W'(icol_r) == w_r - W_W'(1)) begin
          icol_nxt = '0;
          irow_nxt = irow_r + SROW_W'(1);
        end else begin
          icol_nxt = icol_r + COL_W'(1);
        end
        if (lead_r != lag_r) begin
          lead_nxt = lead_r + LAG_W'(1);
        end
        if (gen) begin
          if (W_W'(ocol_r) == w_r - W_W'(1)) begin
            ocol_nxt = '0;
            orow_nxt = orow_r + ROW_W'(1);
          end else begin
            ocol_nxt = ocol_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      icol_r <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      lead_r <= '0;
    end else begin
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      lead_r <= lead_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // line memory: read at transfer, written back from the stage 1 registers later
  // --------------------------------------------------------------------------
  gwc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr_data),
    .rd_en   (take),
    .rd_addr (icol_r),
    .rd_data (line_rd_data)
  );

  always_comb begin
    line_old     = fwd_r ? fwd_data_r : line_rd_data;
    line_wr_data = {line_old[LINE_W-PIX_W-1:0], s1_pix_r};
    line_wr_en   = s1_vld_r && adv;
    // same column read while it is being written back
    fwd_nxt      = s1_vld_r && take && (icol_r == s1_addr_r);
    col_vec[WIN-1] = s1_pix_r;
    for (int k = 0; k < WIN - 1; k++) begin
      col_vec[k] = line_old[(WIN-2-k)*PIX_W +: PIX_W];
    end
    for (int k = 0; k < WIN; k++) begin
      row_tap      = RMSK_W'(s1_row_r) + RMSK_W'(k);
      rmask_nxt[k] = (row_tap >= RMSK_W'(HALF_K)) &&
                     (row_tap < RMSK_W'(h_r) + RMSK_W'(HALF_K));
      col_tap      = CMSK_W'(s1_col_r) + CMSK_W'(k);
      cmask_nxt[k] = (col_tap >= CMSK_W'(HALF_K)) &&
                     (col_tap < CMSK_W'(w_r) + CMSK_W'(HALF_K));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= take;
      fwd_r    <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_gen_r   <= gen;
      s1_last_r  <= last_out;
      s1_pix_r   <= in_pixel;
      s1_addr_r  <= icol_r;
      s1_row_r   <= orow_r;
      s1_col_r   <= ocol_r;
      fwd_data_r <= line_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // window shift
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      for (int j = 0; j < WIN - 1; j++) begin
        for (int k = 0; k < WIN; k++) begin
          win_r[j][k] <= win_r[j+1][k];
        end
      end
      for (int k = 0; k < WIN; k++) begin
        win_r[WIN-1][k] <= col_vec[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // class sums, products, adder tree, round and saturate
  // --------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      for (int k = 0; k < WIN; k++) begin
        mpix[j][k] = (s2_cmask_r[j] && s2_rmask_r[k]) ? win_r[j][k] : '0;
      end
    end
    for (int n = 0; n < NUM_CLS; n++) begin
      s3_cls_nxt[n] = '0;
      for (int j = 0; j < WIN; j++) begin
        for (int k = 0; k < WIN; k++) begin
          if (tap_class(j, k) == CLS_IDX_W'(n)) begin
            s3_cls_nxt[n] = s3_cls_nxt[n] + CLS_W'(mpix[j][k]);
          end
        end
      end
    end
    for (int n = 0; n < NUM_CLS; n++) begin
      s4_prod_nxt[n] = PROD_W'(s3_cls_r[n]) * PROD_W'($signed({1'b0, wgt_r[n]}));
    end
    for (int i = 0; i < NUM_CLS / 2; i++) begin
      s5_pair_nxt[i] = PAIR_W'(s4_prod_r[2*i]) + PAIR_W'(s4_prod_r[2*i+1]);
    end
    acc_nxt = '0;
    for (int i = 0; i < NUM_CLS / 2; i++) begin
      acc_nxt = acc_nxt + ACC_W'(s5_pair_r[i]);
    end
    rnd = s6_acc_r + ACC_W'(2 ** (FRAC_W - 1));
    qv  = Q_W'(rnd >>> FRAC_W);
    if (qv > Q_W'(PIX_MAX)) begin
      filt_nxt = PIX_W'(PIX_MAX);
    end else if (qv < Q_W'(PIX_MIN)) begin
      filt_nxt = PIX_W'(PIX_MIN);
    end else begin
      filt_nxt = PIX_W'(qv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r    <= s1_vld_r && s1_gen_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      out_valid_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r  <= s1_last_r;
      s2_rmask_r <= rmask_nxt;
      s2_cmask_r <= cmask_nxt;
      s3_last_r  <= s2_last_r;
      s4_last_r  <= s3_last_r;
      s5_last_r  <= s4_last_r;
      s6_last_r  <= s5_last_r;
      for (int n = 0; n < NUM_CLS; n++) begin
        s3_cls_r[n]  <= s3_cls_nxt[n];
        s4_prod_r[n] <= s4_prod_nxt[n];
      end
      for (int i = 0; i < NUM_CLS / 2; i++) begin
        s5_pair_r[i] <= s5_pair_nxt[i];
      end
      s6_acc_r        <= acc_nxt;
      out_filtered_r  <= filt_nxt;
      out_frame_end_r <= s6_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_frame_end = out_frame_end_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && last_out) |=>
      (irow_r == '0 && icol_r == '0 && orow_r == '0 && ocol_r == '0 && lead_r == '0))
    else $error("positions not cleared after the last output of a frame");

  a_origin_before_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !gen) |-> (orow_r == '0 && ocol_r == '0))
    else $error("output position moved before the lag was reached");

  a_input_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    gen |-> (irow_r >= SROW_W'(orow_r) + SROW_W'(HALF_K)))
    else $error("output row overtakes the input stream");

  a_center_tap: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_rmask_r[HALF_K] && s2_cmask_r[HALF_K]))
    else $error("center tap masked out");

endmodule

// ===== tb/sv/gaussian_window_convolution_tb.sv =====
// ============================================================================
// gaussian_window_convolution_tb
// Self-checking bench for the streamed 5x5 Gaussian window filter. Frames of
// signed pixels and pad ticks go in over the valid/stall channel; a local
// blur predictor with its own line store works out every filtered pixel and
// frame end flag, and each result transfer is compared in order. Directed
// frames cover rounding, saturation and the dimension limits, then random
// frames with random weights and random idling on both sides, then a probe
// at the clamped widest row and one full frame with no idling.
// ============================================================================
module gaussian_window_convolution_tb;
  import gwc_pkg::*;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_PAD   = 1'b1;
  localparam int   ROW_SLOTS = 2 * FILTER_SPAN;
  localparam int   SETTLE    = 12;

  typedef struct packed {
    pix_t filtered;
    logic frame_end;
  } blur_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_action;
  pix_t                  in_pixel;
  logic                  out_valid;
  logic                  out_stall;
  pix_t                  out_filtered;
  logic                  out_frame_end;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  int unsigned img_width;
  int unsigned img_height;
  wgt_t        class_weight [NUM_CLS];
  pix_t        row_store [ROW_SLOTS * MAX_WIDTH];
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned frame_items;
  int unsigned counted_items;

  blur_result_t expected_q [$];
  int           fail_count;
  bit           idling;

  gaussian_window_convolution u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_filtered  (out_filtered),
    .out_frame_end (out_frame_end),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(24_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned frame_width();
    if (img_width == 0) return 1;
    return (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
  endfunction

  function automatic int unsigned frame_height();
    if (img_height == 0) return 1;
    return (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
  endfunction

  function automatic void restart_frame();
    in_col      = 0;
    in_row      = 0;
    out_col     = 0;
    out_row     = 0;
    frame_items = 0;
  endfunction

  function automatic cls_idx_t weight_class(input int dy, input int dx);
    cls_idx_t cls;
    case (dy * dy + dx * dx)
      0:       cls = CLS_CENTER;
      1:       cls = CLS_EDGE_ONE;
      2:       cls = CLS_DIAG_ONE;
      4:       cls = CLS_EDGE_TWO;
      5:       cls = CLS_KNIGHT;
      default: cls = CLS_DIAG_TWO;
    endcase
    return cls;
  endfunction

  function automatic pix_t blur_at(input int r, input int c, input int w, input int h);
    longint acc;
    longint q;
    int     rr;
    int     cc;
    acc = 0;
    for (int dy = -HALF_K; dy <= HALF_K; dy++) begin
      rr = r + dy;
      if (rr < 0 || rr >= h) continue;
      for (int dx = -HALF_K; dx <= HALF_K; dx++) begin
        cc = c + dx;
        if (cc < 0 || cc >= w) continue;
        acc += longint'(row_store[(rr % ROW_SLOTS) * MAX_WIDTH + cc]) *
               longint'(class_weight[weight_class(dy, dx)]);
      end
    end
    // round half up, then clamp to the pixel range
    q = (acc + 32768) >>> 16;
    if (q > PIX_MAX) q = PIX_MAX;
    if (q < PIX_MIN) q = PIX_MIN;
    return pix_t'(q);
  endfunction

  function automatic void predict_blur(input logic act, input pix_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  lag;
    blur_result_t res;
    w   = frame_width();
    h   = frame_height();
    lag = HALF_K * w + HALF_K;
    if (frame_items < w * h) begin
      // pads before the last pixel are dropped
      if (act == ACT_PAD) return;
      row_store[(in_row % ROW_SLOTS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    frame_items++;
    counted_items++;
    if (frame_items > lag) begin
      res.filtered  = blur_at(out_row, out_col, w, h);
      res.frame_end = (out_row == h - 1) && (out_col == w - 1);
      expected_q.push_back(res);
      if (res.frame_end) begin
        restart_frame();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin : check_results
    blur_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %0d/%0b",
                 $time, out_filtered, out_frame_end);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_filtered !== want.filtered) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d",
                   $time, want.filtered, out_filtered);
          fail_count++;
        end
        if (out_frame_end !== want.frame_end) begin
          $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                   $time, want.frame_end, out_frame_end);
          fail_count++;
        end
      end
    end
  end

  // random backpressure on the result side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic act, input pix_t px);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_pixel  <= px;
    do @(posedge clk); while (in_stall);
    predict_blur(act, px);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_IMAGE_WIDTH: begin
        img_width = data[CFG_W_BITS-1:0];
        restart_frame();
      end
      CFG_IMAGE_HEIGHT: begin
        img_height = data[CFG_H_BITS-1:0];
        restart_frame();
      end
      default: class_weight[idx - CFG_WEIGHT_BASE] = data;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 11))
      0:       return pix_t'(PIX_MIN);
      1:       return pix_t'(PIX_MAX);
      2:       return '0;
      default: return pix_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic set_gauss_weights();
    int taps_in_class [NUM_CLS] = '{1, 4, 4, 4, 8, 4};
    int wt [NUM_CLS];
    int spent;
    spent = 0;
    for (int k = 1; k < NUM_CLS; k++) begin
      wt[k] = $urandom_range(0, 2700);
      spent += taps_in_class[k] * wt[k];
    end
    wt[0] = (65536 - spent > 65535) ? 65535 : 65536 - spent;
    for (int k = 0; k < NUM_CLS; k++) begin
      cfg_write(CFG_WEIGHT_BASE + cfg_idx_t'(k), CFG_DATA_W'(wt[k]));
    end
  endtask

  task automatic set_wild_weights();
    logic [CFG_DATA_W-1:0] wt;
    for (int k = 0; k < NUM_CLS; k++) begin
      case ($urandom_range(0, 3))
        0:       wt = '0;
        1:       wt = '1;
        default: wt = CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      cfg_write(CFG_WEIGHT_BASE + cfg_idx_t'(k), wt);
    end
  endtask

  // pixels with stray pads, then the flush; cut_short stops partway
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit cut_short);
    int unsigned total;
    int unsigned stop_at;
    total   = w * h;
    stop_at = total + HALF_K * w + HALF_K;
    if (cut_short) stop_at = $urandom_range(1, stop_at - 1);
    for (int unsigned n = 0; n < stop_at; n++) begin
      if (n < total) begin
        if ($urandom_range(0, 9) == 0) send_item(ACT_PAD, rand_pixel());
        send_item(ACT_PIXEL, rand_pixel());
      end else begin
        send_item(($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_PAD, rand_pixel());
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_reset_weights_rounding();
    pix_t px [9] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
                     16'sh5555, 16'shaaaa, 16'sh0002, 16'shfffe};
    // pad into a fresh frame at reset size is dropped
    send_item(ACT_PAD, 16'sh1234);
    drain();
    set_frame_size(3, 3);
    for (int k = 0; k < 9; k++) begin
      send_item(ACT_PIXEL, px[k]);
      if (k == 3) send_item(ACT_PAD, 16'sh7fff);
    end
    // pixels past the frame flush like pads
    for (int k = 0; k < 8; k++) send_item(k[0] ? ACT_PIXEL : ACT_PAD, px[k]);
    drain();
  endtask

  task automatic test_saturation();
    for (int k = 0; k < NUM_CLS; k++) cfg_write(CFG_WEIGHT_BASE + cfg_idx_t'(k), '1);
    set_frame_size(2, 1);
    send_item(ACT_PIXEL, pix_t'(PIX_MAX));
    send_item(ACT_PIXEL, pix_t'(PIX_MAX));
    repeat (HALF_K * 2 + HALF_K) send_item(ACT_PAD, '0);
    drain();
  endtask

  task automatic test_zero_dimensions();
    set_frame_size(0, 0);
    send_item(ACT_PIXEL, 16'sh4321);
    repeat (HALF_K * 1 + HALF_K) send_item(ACT_PAD, '1);
    drain();
  endtask

  task automatic test_tall_column();
    idling = 1'b1;
    set_gauss_weights();
    set_frame_size(1, 16'h1fff);
    for (int k = 0; k < 60; k++) begin
      if ($urandom_range(0, 5) == 0) send_item(ACT_PAD, rand_pixel());
      send_item(ACT_PIXEL, rand_pixel());
    end
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    bit          cut;
    start = counted_items;
    while (counted_items - start < 360) begin
      drain();
      idling = ($urandom_range(0, 4) != 0);
      w      = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      h      = $urandom_range(1, 6);
      set_frame_size(w, h);
      if ($urandom_range(0, 2) == 0) set_wild_weights();
      else set_gauss_weights();
      frames = $urandom_range(1, 2);
      cut    = ($urandom_range(0, 5) == 0);
      for (int unsigned f = 0; f < frames; f++) run_frame(w, h, cut && f == frames - 1);
    end
    drain();
  endtask

  task automatic test_wide_rows();
    idling = 1'b0;
    drain();
    set_gauss_weights();
    // widest row setting clamps, no result is due this early
    set_frame_size(16'h07ff, 3);
    repeat (100) send_item(ACT_PIXEL, rand_pixel());
    drain();
    set_frame_size(64, 2);
    run_frame(64, 2, 1'b0);
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_PIXEL;
    in_pixel  = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    idling    = 1'b0;
    fail_count    = 0;
    counted_items = 0;
    img_width     = RST_WIDTH;
    img_height    = RST_HEIGHT;
    class_weight  = '{default: '0};
    class_weight[CLS_CENTER] = WGT_W'(RST_CENTER);
    foreach (row_store[k]) row_store[k] = '0;
    restart_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_weights_rounding();
    test_saturation();
    test_zero_dimensions();
    test_tall_column();
    test_random_frames();
    test_wide_rows();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== gaussian_window_convolution.f =====
src/gwc_pkg.sv
src/gwc_ram.sv
src/gaussian_window_convolution.sv
tb/sv/gaussian_window_convolution_tb.sv
